>>> hw/rtl/ipd_dfr_pkg.sv
// Package for the IPD payload deframer: frame phase type, result record,
// header characters and fixed field widths. No dependencies.
package ipd_dfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 7;
    localparam int unsigned ID_W    = 4;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned COUNT_W = 8;

    localparam logic [COUNT_W-1:0] MAX_PAYLOAD = 8'd128;
    localparam logic [LEN_W-1:0]   LEN_SAT     = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_CLIENT  = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]  payload_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [ID_W-1:0]    conn_id;
        logic [LEN_W-1:0]   declared_length;
        logic               last;
    } t_result;

endpackage

>>> hw/rtl/ipd_dfr_if.sv
// Valid/ready channel interfaces of the IPD payload deframer.
// Depends on ipd_dfr_pkg for field widths.
interface ipd_dfr_rx_if;
    logic                            valid;
    logic                            ready;
    logic [ipd_dfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_dfr_pl_if;
    logic                            valid;
    logic                            ready;
    logic [ipd_dfr_pkg::BYTE_W-1:0]  payload_byte;
    logic [ipd_dfr_pkg::INDEX_W-1:0] byte_index;
    logic [ipd_dfr_pkg::ID_W-1:0]    conn_id;
    logic [ipd_dfr_pkg::LEN_W-1:0]   declared_length;
    logic                            last;

    modport source (output valid, output payload_byte, output byte_index, output conn_id,
                    output declared_length, output last, input ready);
    modport sink   (input valid, input payload_byte, input byte_index, input conn_id,
                    input declared_length, input last, output ready);
endinterface

>>> hw/rtl/at_ipd_payload_deframer_core.sv
// IPD payload deframer top level: input register, frame parser, result register.
// An accepted byte is held in the input register; its result then loads the result register.
// Throughput: one byte per cycle; i_rx stalls only while a result waits on o_pl
// and the held byte would produce another.
// Reset: synchronous, active low; clears the window, phase, counters, client and mux_enabled.
// Depends on ipd_dfr_pkg, ipd_dfr_if and ipd_dfr_parser.
module at_ipd_payload_deframer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    ipd_dfr_rx_if.sink          i_rx,
    ipd_dfr_pl_if.source        o_pl
);

    logic                           r_mux_en;
    logic                           r_in_valid;
    logic [ipd_dfr_pkg::BYTE_W-1:0] r_in_byte;
    logic                           r_out_valid;
    ipd_dfr_pkg::t_result           r_out;

    logic                           emit;
    ipd_dfr_pkg::t_result           result;
    logic                           out_free;
    logic                           advance;

    assign out_free   = !r_out_valid || o_pl.ready;
    assign advance    = r_in_valid && (!emit || out_free);
    assign i_rx.ready = !r_in_valid || advance;

    ipd_dfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_mux_en (r_mux_en),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_mux_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pl.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_pl.valid           = r_out_valid;
    assign o_pl.payload_byte    = r_out.payload_byte;
    assign o_pl.byte_index      = r_out.byte_index;
    assign o_pl.conn_id         = r_out.conn_id;
    assign o_pl.declared_length = r_out.declared_length;
    assign o_pl.last            = r_out.last;

endmodule

>>> hw/rtl/ipd_dfr_parser.sv
// Frame parser of the IPD payload deframer: byte window, phase machine,
// client id, length accumulator and payload counter. Depends on ipd_dfr_pkg.
module ipd_dfr_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [ipd_dfr_pkg::BYTE_W-1:0] i_byte,
    input  logic                           i_mux_en,
    output logic                           o_emit,
    output ipd_dfr_pkg::t_result           o_result
);

    logic [ipd_dfr_pkg::BYTE_W-1:0]  r_recent [4];
    ipd_dfr_pkg::t_phase             r_phase, n_phase;
    logic [ipd_dfr_pkg::LEN_W-1:0]   r_len, n_len;
    logic [ipd_dfr_pkg::COUNT_W-1:0] r_count, n_count;
    logic [ipd_dfr_pkg::ID_W-1:0]    r_client, n_client;

    logic                            hdr;
    logic                            is_digit;
    logic [ipd_dfr_pkg::ID_W-1:0]    digit;
    logic [ipd_dfr_pkg::LEN_W+3:0]   len_mul;
    logic [ipd_dfr_pkg::LEN_W-1:0]   len_next;
    logic [ipd_dfr_pkg::COUNT_W-1:0] count_inc;
    logic                            done;

    assign hdr = (r_recent[0] == ipd_dfr_pkg::CH_PLUS) && (r_recent[1] == ipd_dfr_pkg::CH_I) &&
                 (r_recent[2] == ipd_dfr_pkg::CH_P) && (r_recent[3] == ipd_dfr_pkg::CH_D) &&
                 (i_byte == ipd_dfr_pkg::CH_COMMA);
    assign is_digit  = (i_byte >= ipd_dfr_pkg::CH_ZERO) && (i_byte <= ipd_dfr_pkg::CH_NINE);
    assign digit     = i_byte[ipd_dfr_pkg::ID_W-1:0];
    assign len_mul   = ({4'd0, r_len} << 3) + ({4'd0, r_len} << 1) + {16'd0, digit};
    assign len_next  = (len_mul[ipd_dfr_pkg::LEN_W+3:ipd_dfr_pkg::LEN_W] != 4'd0) ?
                       ipd_dfr_pkg::LEN_SAT : len_mul[ipd_dfr_pkg::LEN_W-1:0];
    assign count_inc = r_count + 8'd1;
    assign done      = ({8'd0, count_inc} == r_len) || (count_inc >= ipd_dfr_pkg::MAX_PAYLOAD);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            ipd_dfr_pkg::PH_HUNT: begin
                if (hdr) begin
                    n_phase = i_mux_en ? ipd_dfr_pkg::PH_CLIENT : ipd_dfr_pkg::PH_LENGTH;
                end
            end
            ipd_dfr_pkg::PH_CLIENT: begin
                if (i_byte == ipd_dfr_pkg::CH_COMMA) begin
                    n_phase = ipd_dfr_pkg::PH_LENGTH;
                end
            end
            ipd_dfr_pkg::PH_LENGTH: begin
                if (i_byte == ipd_dfr_pkg::CH_COLON) begin
                    n_phase = ipd_dfr_pkg::PH_PAYLOAD;
                end
            end
            ipd_dfr_pkg::PH_PAYLOAD: begin
                if (done) begin
                    n_phase = ipd_dfr_pkg::PH_HUNT;
                end
            end
            default: n_phase = ipd_dfr_pkg::PH_HUNT;
        endcase
    end

    always_comb begin
        n_len    = r_len;
        n_count  = r_count;
        n_client = r_client;
        o_emit   = 1'b0;
        o_result.payload_byte    = i_byte;
        o_result.byte_index      = r_count[ipd_dfr_pkg::INDEX_W-1:0];
        o_result.conn_id         = r_client;
        o_result.declared_length = r_len;
        o_result.last            = done;
        unique case (r_phase)
            ipd_dfr_pkg::PH_HUNT: begin
                if (hdr) begin
                    n_client = '0;
                end
            end
            ipd_dfr_pkg::PH_CLIENT: begin
                if (i_byte != ipd_dfr_pkg::CH_COMMA) begin
                    n_client = is_digit ? digit : '0;
                end
            end
            ipd_dfr_pkg::PH_LENGTH: begin
                if (is_digit) begin
                    n_len = len_next;
                end
            end
            ipd_dfr_pkg::PH_PAYLOAD: begin
                o_emit = 1'b1;
                if (done) begin
                    n_len   = '0;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            default: o_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent[0] <= '0;
            r_recent[1] <= '0;
            r_recent[2] <= '0;
            r_recent[3] <= '0;
            r_phase     <= ipd_dfr_pkg::PH_HUNT;
            r_len       <= '0;
            r_count     <= '0;
            r_client    <= '0;
        end else if (i_step) begin
            r_recent[0] <= r_recent[1];
            r_recent[1] <= r_recent[2];
            r_recent[2] <= r_recent[3];
            r_recent[3] <= i_byte;
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_count     <= n_count;
            r_client    <= n_client;
        end
    end

endmodule

>>> hw/rtl/ipd_dfr_checker.sv
// Port-level checker for the IPD payload deframer and its bind to the top level.
// Depends on ipd_dfr_pkg and at_ipd_payload_deframer_core.
module ipd_dfr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_pl_valid,
    input logic                            i_pl_ready,
    input logic [ipd_dfr_pkg::BYTE_W-1:0]  i_pl_byte,
    input logic [ipd_dfr_pkg::INDEX_W-1:0] i_pl_index,
    input logic [ipd_dfr_pkg::ID_W-1:0]    i_pl_client,
    input logic [ipd_dfr_pkg::LEN_W-1:0]   i_pl_length,
    input logic                            i_pl_last
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_pl_valid)
        else $error("result request visible right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pl_valid && !i_pl_ready |=> i_pl_valid && $stable(i_pl_byte) &&
        $stable(i_pl_index) && $stable(i_pl_last))
        else $error("stalled result request changed");

    a_client_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pl_valid |-> i_pl_client <= 4'd9)
        else $error("client id out of decimal range");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pl_valid && i_pl_last && (i_pl_length != 16'd0) &&
        (i_pl_length <= {8'd0, ipd_dfr_pkg::MAX_PAYLOAD}) && (i_pl_length <= 16'd128)
        |-> ({9'd0, i_pl_index} + 16'd1) == i_pl_length)
        else $error("last flag does not match declared length");

endmodule

bind at_ipd_payload_deframer_core ipd_dfr_checker u_ipd_dfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pl_valid  (o_pl.valid),
    .i_pl_ready  (o_pl.ready),
    .i_pl_byte   (o_pl.payload_byte),
    .i_pl_index  (o_pl.byte_index),
    .i_pl_client (o_pl.conn_id),
    .i_pl_length (o_pl.declared_length),
    .i_pl_last   (o_pl.last)
);
